// ===== sv/lrupr_pkg.sv =====
`default_nettype none
package lrupr_pkg;

    localparam int FRAMES    = 8;
    localparam int PAGE_BITS = 16;
    localparam int ID_W      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RANK_W    = ID_W;
    localparam int ACT_W     = $clog2(FRAMES + 1);
    localparam int CFG_W     = 4;
    localparam int COUNT_W   = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = CFG_W'(8);
    localparam logic [COUNT_W-1:0] FAULT_MAX = {COUNT_W{1'b1}};

    typedef logic [ID_W-1:0]      t_idx;
    typedef logic [RANK_W-1:0]    t_rank;
    typedef logic [PAGE_BITS-1:0] t_page;
    typedef logic [ACT_W-1:0]     t_act;

    typedef struct packed {
        logic  hit_found;
        t_idx  hit_idx;
        t_rank hit_rank;
        logic  empty_found;
        t_idx  empty_idx;
        logic  max_found;
        t_idx  max_idx;
        t_rank max_rank;
        t_page max_page;
    } t_chain;

    typedef struct packed {
        logic  en;
        logic  clear;
        logic  fill;
        logic  miss;
        t_idx  slot;
        t_rank limit;
        t_page page;
    } t_upd;

endpackage
`default_nettype wire

// ===== sv/lrupr_in_if.sv =====
`default_nettype none
interface lrupr_in_if;
    logic                 valid;
    logic                 ready;
    lrupr_pkg::t_page     page_number;
    logic                 last_ref;

    modport source (output valid, page_number, last_ref, input ready);
    modport sink   (input valid, page_number, last_ref, output ready);
endinterface
`default_nettype wire

// ===== sv/lrupr_out_if.sv =====
`default_nettype none
interface lrupr_out_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    lrupr_pkg::t_idx              frame_slot;
    logic                         evicted_valid;
    lrupr_pkg::t_page             evicted_page;
    logic [lrupr_pkg::COUNT_W-1:0] fault_count;

    modport source (output valid, hit, frame_slot, evicted_valid, evicted_page, fault_count,
                    input ready);
    modport sink   (input valid, hit, frame_slot, evicted_valid, evicted_page, fault_count,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/lrupr_cell.sv =====
`default_nettype none
module lrupr_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire lrupr_pkg::t_idx   i_index,
    input  wire lrupr_pkg::t_act   i_active,
    input  wire lrupr_pkg::t_upd   i_upd,
    input  wire lrupr_pkg::t_chain i_chain,
    output lrupr_pkg::t_chain      o_chain
);

    lrupr_pkg::t_page r_page;
    logic             r_valid;
    lrupr_pkg::t_rank r_rank;

    lrupr_pkg::t_page n_page;
    logic             n_valid;
    lrupr_pkg::t_rank n_rank;

    logic active;
    logic match;
    logic sel;

    assign active = lrupr_pkg::ACT_W'(i_index) < i_active;
    assign match  = active && r_valid && (r_page == i_upd.page);
    assign sel    = (i_upd.slot == i_index);

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.hit_found && match) begin
            o_chain.hit_found = 1'b1;
            o_chain.hit_idx   = i_index;
            o_chain.hit_rank  = r_rank;
        end
        if (!i_chain.empty_found && active && !r_valid) begin
            o_chain.empty_found = 1'b1;
            o_chain.empty_idx   = i_index;
        end
        if (active && (!i_chain.max_found || r_rank > i_chain.max_rank)) begin
            o_chain.max_found = 1'b1;
            o_chain.max_idx   = i_index;
            o_chain.max_rank  = r_rank;
            o_chain.max_page  = r_page;
        end
    end

    always_comb begin
        n_page  = r_page;
        n_valid = r_valid;
        n_rank  = r_rank;
        if (i_upd.en) begin
            if (i_upd.clear) begin
                n_valid = 1'b0;
                n_rank  = '0;
            end else if (sel) begin
                n_rank = '0;
                if (i_upd.miss) begin
                    n_page  = i_upd.page;
                    n_valid = 1'b1;
                end
            end else if (r_valid && (i_upd.fill || r_rank < i_upd.limit)) begin
                n_rank = r_rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_page <= n_page;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            r_valid <= n_valid;
            r_rank  <= n_rank;
        end
    end

endmodule
`default_nettype wire

// ===== sv/lru_page_replacement.sv =====
// LRU page replacement unit.
// Input channel i_in carries one page reference per transaction (page_number,
// last_ref). Output channel o_out returns one result per reference: hit flag,
// frame slot, evicted page (zero when none) and the saturating fault count.
// i_cfg_we / i_cfg_data write frames_in_use; 0 acts as 1, values above the
// frame count act as the frame count. Write it only while the block is idle.
// The result is registered on the edge that accepts the reference. Throughput
// is one reference per cycle while the receiver takes each result; the frame
// cells compare all entries in parallel and the search result ripples down
// the row of cells. A reference with last_ref set clears the table and fault
// count after its result is formed. Reset empties every frame, clears the
// fault count and sets frames_in_use to 8. When the receiver stalls, the
// result is held in the output register and i_in.ready drops until it is taken.
`default_nettype none
module lru_page_replacement (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [lrupr_pkg::CFG_W-1:0] i_cfg_data,
    lrupr_in_if.sink                         i_in,
    lrupr_out_if.source                      o_out
);

    logic [lrupr_pkg::CFG_W-1:0]   r_cfg;
    logic [lrupr_pkg::COUNT_W-1:0] r_fault;
    logic [lrupr_pkg::COUNT_W-1:0] n_fault;
    logic                          r_out_valid;
    logic                          r_hit;
    lrupr_pkg::t_idx               r_slot;
    logic                          r_ev_valid;
    lrupr_pkg::t_page              r_ev_page;
    logic [lrupr_pkg::COUNT_W-1:0] r_count;

    lrupr_pkg::t_chain chain [0:lrupr_pkg::FRAMES];
    lrupr_pkg::t_upd   upd;
    lrupr_pkg::t_act   active;
    logic              accept;
    logic              hit;
    logic              fill;
    logic              evict;
    lrupr_pkg::t_page  ev_page;
    logic [lrupr_pkg::COUNT_W-1:0] fault_inc;

    always_comb begin
        if (r_cfg == '0) begin
            active = lrupr_pkg::ACT_W'(1);
        end else if (int'(r_cfg) > lrupr_pkg::FRAMES) begin
            active = lrupr_pkg::ACT_W'(lrupr_pkg::FRAMES);
        end else begin
            active = lrupr_pkg::ACT_W'(r_cfg);
        end
    end

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    assign chain[0] = '0;

    for (genvar g = 0; g < lrupr_pkg::FRAMES; g++) begin : g_cell
        lrupr_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_index  (lrupr_pkg::ID_W'(g)),
            .i_active (active),
            .i_upd    (upd),
            .i_chain  (chain[g]),
            .o_chain  (chain[g+1])
        );
    end

    assign hit     = chain[lrupr_pkg::FRAMES].hit_found;
    assign fill    = !hit && chain[lrupr_pkg::FRAMES].empty_found;
    assign evict   = !hit && !fill;
    assign ev_page = evict ? chain[lrupr_pkg::FRAMES].max_page : '0;

    always_comb begin
        upd.en    = accept;
        upd.clear = i_in.last_ref;
        upd.fill  = fill;
        upd.miss  = !hit;
        upd.page  = i_in.page_number;
        if (hit) begin
            upd.slot  = chain[lrupr_pkg::FRAMES].hit_idx;
            upd.limit = chain[lrupr_pkg::FRAMES].hit_rank;
        end else if (fill) begin
            upd.slot  = chain[lrupr_pkg::FRAMES].empty_idx;
            upd.limit = chain[lrupr_pkg::FRAMES].max_rank;
        end else begin
            upd.slot  = chain[lrupr_pkg::FRAMES].max_idx;
            upd.limit = chain[lrupr_pkg::FRAMES].max_rank;
        end
    end

    assign fault_inc = (!hit && r_fault != lrupr_pkg::FAULT_MAX) ? r_fault + 1'b1 : r_fault;

    always_comb begin
        n_fault = r_fault;
        if (accept) begin
            n_fault = i_in.last_ref ? '0 : fault_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= lrupr_pkg::CFG_RESET;
            r_fault     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
            r_fault <= n_fault;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hit      <= hit;
            r_slot     <= upd.slot;
            r_ev_valid <= evict;
            r_ev_page  <= ev_page;
            r_count    <= fault_inc;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hit           = r_hit;
    assign o_out.frame_slot    = r_slot;
    assign o_out.evicted_valid = r_ev_valid;
    assign o_out.evicted_page  = r_ev_page;
    assign o_out.fault_count   = r_count;

endmodule
`default_nettype wire

// ===== sv/lrupr_checker.sv =====
`default_nettype none
module lrupr_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic                          i_hit,
    input wire logic                          i_ev_valid,
    input wire lrupr_pkg::t_page              i_ev_page,
    input wire logic [lrupr_pkg::COUNT_W-1:0] i_count
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("no result one cycle after accepted reference");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_hit && i_ev_valid) && (i_ev_valid || i_ev_page == '0))
        else $error("eviction fields inconsistent with hit");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            i_out_valid && $stable(i_hit) && $stable(i_ev_page) && $stable(i_count))
        else $error("stalled result changed");

endmodule

bind lru_page_replacement lrupr_checker u_lrupr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_hit       (o_out.hit),
    .i_ev_valid  (o_out.evicted_valid),
    .i_ev_page   (o_out.evicted_page),
    .i_count     (o_out.fault_count)
);
`default_nettype wire
